@@ hw/rtl/psw_pkg.sv @@
// Shared constants and types for the priority schedule block.
package psw_pkg;
  localparam int MaxProc = 32;
  localparam int IdxW = $clog2(MaxProc);
  localparam int CntW = IdxW + 1;
  localparam int RecW = 32;
  localparam int SumW = 30;

  typedef struct packed {
    logic [7:0]  prio;
    logic [15:0] burst;
    logic [7:0]  id;
  } rec_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic            dropped;
  } job_t;
endpackage

@@ hw/rtl/psw_ram.sv @@
// Generic single-port-write, one-read RAM with registered read.
module psw_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ hw/rtl/psw_front.sv @@
// Front end: loads records into the store and posts a job on the last one.
module psw_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic [7:0]              process_id_i,
  input  logic [15:0]             burst_time_i,
  input  logic [7:0]              priority_req_i,
  input  logic                    last_i,
  input  logic                    store_free_i,
  output logic                    we_o,
  output logic [psw_pkg::IdxW-1:0] waddr_o,
  output psw_pkg::rec_t           wdata_o,
  output logic                    job_valid_o,
  output psw_pkg::job_t           job_o,
  input  logic                    job_ready_i
);
  import psw_pkg::*;

  logic [CntW-1:0] count_q, count_d;
  logic            drop_q, drop_d;
  logic            job_valid_q;
  job_t            job_q;
  logic            acc, room;

  assign ready_o = store_free_i && !job_valid_q;
  assign acc     = valid_i && ready_o;
  assign room    = count_q < CntW'(MaxProc);
  assign we_o    = acc && room;
  assign waddr_o = count_q[IdxW-1:0];
  assign wdata_o = '{prio: priority_req_i, burst: burst_time_i, id: process_id_i};
  assign job_valid_o = job_valid_q;
  assign job_o = job_q;

  always_comb begin
    count_d = count_q;
    drop_d  = drop_q;
    if (acc) begin
      if (room) begin
        count_d = count_q + CntW'(1);
      end else begin
        drop_d = 1'b1;
      end
      if (last_i) begin
        count_d = '0;
        drop_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      drop_q      <= 1'b0;
      job_valid_q <= 1'b0;
      job_q       <= '0;
    end else begin
      count_q <= count_d;
      drop_q  <= drop_d;
      if (job_valid_q && job_ready_i) begin
        job_valid_q <= 1'b0;
      end
      if (acc && last_i) begin
        job_valid_q   <= 1'b1;
        job_q.count   <= room ? count_q + CntW'(1) : count_q;
        job_q.dropped <= drop_q || !room;
      end
    end
  end
endmodule

@@ hw/rtl/psw_back.sv @@
// Back end: exchange sort, prefix sums, averaging divider and result output.
module psw_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     job_valid_i,
  input  psw_pkg::job_t            job_i,
  output logic                     job_ready_o,
  output logic                     store_free_o,
  output logic [psw_pkg::IdxW-1:0] raddr_o,
  input  psw_pkg::rec_t            rdata_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic [7:0]               process_id_res_o,
  output logic [15:0]              burst_time_res_o,
  output logic [21:0]              wait_time_o,
  output logic [21:0]              turnaround_time_o,
  output logic [29:0]              average_wait_o,
  output logic [29:0]              average_turnaround_o,
  output logic                     overflowed_o,
  output logic                     final_res_o
);
  import psw_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StLoad, StSort, StEmit, StDiv, StOut
  } state_e;

  state_e          state_q;
  rec_t            work_q [MaxProc];
  logic [CntW-1:0] n_q, i_q, j_q;
  logic            drop_q;
  logic [21:0]     wait_q;
  logic [SumW+8-1:0] sw_q, st_q;
  logic [SumW+8-1:0] qw_q, qt_q;
  logic [CntW-1:0] rw_q, rt_q;
  logic [5:0]      bit_q;
  logic [CntW:0]   trw, trt;
  rec_t            ri, rj, cur;
  logic [21:0]     tat;

  assign job_ready_o  = state_q == StIdle;
  assign store_free_o = state_q == StIdle && !job_valid_i;
  assign raddr_o      = i_q[IdxW-1:0];
  assign ri  = work_q[i_q[IdxW-1:0]];
  assign rj  = work_q[j_q[IdxW-1:0]];
  assign cur = work_q[i_q[IdxW-1:0]];
  assign tat = wait_q + 22'(cur.burst);
  assign trw = {rw_q, qw_q[SumW+7]} - {1'b0, n_q};
  assign trt = {rt_q, qt_q[SumW+7]} - {1'b0, n_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_o <= 1'b0;
      final_res_o <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (job_valid_i) begin
            n_q    <= job_i.count;
            drop_q <= job_i.dropped;
            i_q    <= '0;
            state_q <= StLoad;
          end
        end
        StLoad: begin
          if (i_q != '0) begin
            work_q[i_q[IdxW-1:0] - IdxW'(1)] <= rdata_i;
          end
          if (i_q == n_q) begin
            i_q <= '0;
            j_q <= CntW'(1);
            state_q <= StSort;
          end else begin
            i_q <= i_q + CntW'(1);
          end
        end
        StSort: begin
          if (j_q >= n_q) begin
            if (i_q + CntW'(1) >= n_q) begin
              i_q <= '0;
              wait_q <= '0;
              sw_q <= '0;
              st_q <= '0;
              state_q <= (n_q == '0) ? StIdle : StEmit;
            end else begin
              i_q <= i_q + CntW'(1);
              j_q <= i_q + CntW'(2);
            end
          end else begin
            if (ri.prio > rj.prio) begin
              work_q[i_q[IdxW-1:0]] <= rj;
              work_q[j_q[IdxW-1:0]] <= ri;
            end
            j_q <= j_q + CntW'(1);
          end
        end
        StEmit: begin
          if (!valid_o || ready_i) begin
            valid_o <= (i_q + CntW'(1) != n_q);
            process_id_res_o <= cur.id;
            burst_time_res_o <= cur.burst;
            wait_time_o <= wait_q;
            turnaround_time_o <= tat;
            average_wait_o <= '0;
            average_turnaround_o <= '0;
            overflowed_o <= drop_q;
            final_res_o <= 1'b0;
            sw_q <= sw_q + (38'(wait_q) << 8);
            st_q <= st_q + (38'(tat) << 8);
            wait_q <= tat;
            if (i_q + CntW'(1) == n_q) begin
              qw_q <= sw_q + (38'(wait_q) << 8);
              qt_q <= st_q + (38'(tat) << 8);
              rw_q <= '0;
              rt_q <= '0;
              bit_q <= 6'd38;
              state_q <= StDiv;
            end else begin
              i_q <= i_q + CntW'(1);
            end
          end
        end
        StDiv: begin
          if (bit_q == '0) begin
            state_q <= StOut;
          end else begin
            bit_q <= bit_q - 6'd1;
            if (!trw[CntW]) begin
              rw_q <= trw[CntW-1:0];
              qw_q <= {qw_q[SumW+6:0], 1'b1};
            end else begin
              rw_q <= {rw_q[CntW-2:0], qw_q[SumW+7]};
              qw_q <= {qw_q[SumW+6:0], 1'b0};
            end
            if (!trt[CntW]) begin
              rt_q <= trt[CntW-1:0];
              qt_q <= {qt_q[SumW+6:0], 1'b1};
            end else begin
              rt_q <= {rt_q[CntW-2:0], qt_q[SumW+7]};
              qt_q <= {qt_q[SumW+6:0], 1'b0};
            end
          end
        end
        StOut: begin
          if (!valid_o || ready_i) begin
            valid_o <= 1'b1;
            process_id_res_o <= cur.id;
            burst_time_res_o <= cur.burst;
            wait_time_o <= wait_q - 22'(cur.burst);
            turnaround_time_o <= wait_q;
            average_wait_o <= qw_q[SumW-1:0];
            average_turnaround_o <= qt_q[SumW-1:0];
            overflowed_o <= drop_q;
            final_res_o <= 1'b1;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
      if (state_q != StEmit && state_q != StOut && valid_o && ready_i) begin
        valid_o <= 1'b0;
      end
    end
  end
endmodule

@@ hw/rtl/priority_schedule_wait_times.sv @@
// Top level of the non-preemptive priority scheduler.
// Input channel (valid_i/ready_o) carries process records: id, burst time,
// priority and a last mark. Up to 32 records are stored per set; more are
// dropped and flagged on every result of the set. The last-marked record
// starts a job: records are read back, exchange-sorted by
// priority in one compare per cycle, and emitted in schedule order one per
// cycle while ready_i is high, with wait and turnaround times. Before the
// final result a restoring divider forms both averages with 8 fraction
// bits, truncated.
// A one-entry job queue hands the set to the back end; records of the next
// set are held off until the back end is idle again.
// Output (valid_o/ready_i) is a single register; a stall on ready_i holds
// the result and pauses the back end. Reset empties the job queue, clears
// the record count and drop flag, and drops any result in flight.
module priority_schedule_wait_times (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [7:0]  process_id_i,
  input  logic [15:0] burst_time_i,
  input  logic [7:0]  priority_req_i,
  input  logic        last_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [7:0]  process_id_res_o,
  output logic [15:0] burst_time_res_o,
  output logic [21:0] wait_time_o,
  output logic [21:0] turnaround_time_o,
  output logic [29:0] average_wait_o,
  output logic [29:0] average_turnaround_o,
  output logic        overflowed_o,
  output logic        final_res_o
);
  import psw_pkg::*;

  logic            we, job_valid, job_ready, store_free;
  logic [IdxW-1:0] waddr, raddr;
  rec_t            wdata, rdata;
  job_t            job;

  psw_front u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o,
    .process_id_i, .burst_time_i, .priority_req_i, .last_i,
    .store_free_i(store_free), .we_o(we), .waddr_o(waddr), .wdata_o(wdata),
    .job_valid_o(job_valid), .job_o(job), .job_ready_i(job_ready)
  );

  psw_ram #(.Width(RecW), .Depth(MaxProc)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  psw_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_i(job),
    .job_ready_o(job_ready), .store_free_o(store_free),
    .raddr_o(raddr), .rdata_i(rdata),
    .valid_o, .ready_i,
    .process_id_res_o, .burst_time_res_o, .wait_time_o, .turnaround_time_o,
    .average_wait_o, .average_turnaround_o, .overflowed_o, .final_res_o
  );
endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the priority schedule block: directed and random record sets vs. a predictor.
`timescale 1ns / 1ps

module tb_top;
  import psw_pkg::*;

  typedef struct {
    logic [7:0]  id;
    logic [15:0] burst;
    logic [7:0]  prio;
    logic        last;
    bit          drain;
  } proc_item_t;

  typedef struct {
    logic [7:0]  id;
    logic [15:0] burst;
    logic [21:0] wait_t;
    logic [21:0] tat;
    logic [29:0] avg_wait;
    logic [29:0] avg_tat;
    logic        ovf;
    logic        fin;
  } sched_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        valid_i;
  logic        ready_o;
  logic [7:0]  process_id_i;
  logic [15:0] burst_time_i;
  logic [7:0]  priority_req_i;
  logic        last_i;
  logic        valid_o;
  logic        ready_i;
  logic [7:0]  process_id_res_o;
  logic [15:0] burst_time_res_o;
  logic [21:0] wait_time_o;
  logic [21:0] turnaround_time_o;
  logic [29:0] average_wait_o;
  logic [29:0] average_turnaround_o;
  logic        overflowed_o;
  logic        final_res_o;

  proc_item_t pending_q[$];
  sched_res_t sched_q[$];
  rec_t       rec_store[MaxProc];
  int         rec_count;
  bit         rec_dropped;
  int         errors;
  int         gap_cnt;
  int         stall_cnt;
  longint     cycles = 0;

  priority_schedule_wait_times u_top (.*);

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int draw_pause();
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 14) : 0;
  endfunction

  function automatic void schedule_set(logic [7:0] id, logic [15:0] bt, logic [7:0] pr,
                                       logic last);
    rec_t       work[MaxProc];
    rec_t       t;
    sched_res_t r;
    longint     wacc;
    longint     sum_w;
    longint     sum_t;
    int         n;
    if (rec_count < MaxProc) begin
      rec_store[rec_count] = '{prio: pr, burst: bt, id: id};
      rec_count++;
    end else begin
      rec_dropped = 1'b1;
    end
    if (!last) return;
    n = rec_count;
    work = rec_store;
    for (int i = 0; i < n; i++)
      for (int j = i + 1; j < n; j++)
        if (work[i].prio > work[j].prio) begin
          t = work[i];
          work[i] = work[j];
          work[j] = t;
        end
    wacc = 0;
    sum_w = 0;
    sum_t = 0;
    for (int i = 0; i < n; i++) begin
      r.id = work[i].id;
      r.burst = work[i].burst;
      r.wait_t = wacc[21:0];
      r.tat = wacc + work[i].burst;
      r.avg_wait = '0;
      r.avg_tat = '0;
      r.ovf = rec_dropped;
      r.fin = 1'b0;
      sum_w += wacc;
      sum_t += wacc + work[i].burst;
      wacc += work[i].burst;
      if (i == n - 1) begin
        r.avg_wait = ((sum_w << 8) / n);
        r.avg_tat = ((sum_t << 8) / n);
        r.fin = 1'b1;
      end
      sched_q.push_back(r);
    end
    rec_count = 0;
    rec_dropped = 1'b0;
  endfunction

  function automatic void add_item(logic [7:0] id, logic [15:0] bt, logic [7:0] pr,
                                   logic last, bit drain);
    pending_q.push_back('{id: id, burst: bt, prio: pr, last: last, drain: drain});
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_i <= 1'b0;
      process_id_i <= '0;
      burst_time_i <= '0;
      priority_req_i <= '0;
      last_i <= 1'b0;
      gap_cnt <= 0;
    end else begin
      if (valid_i && ready_o) begin
        schedule_set(process_id_i, burst_time_i, priority_req_i, last_i);
      end
      if (!valid_i || ready_o) begin
        if (valid_i && ready_o && draw_pause() > 0) begin
          gap_cnt <= draw_pause();
          valid_i <= 1'b0;
        end else if (gap_cnt > 0) begin
          gap_cnt <= gap_cnt - 1;
          valid_i <= 1'b0;
        end else if (pending_q.size() > 0 &&
                     (!pending_q[0].drain || sched_q.size() == 0)) begin
          process_id_i <= pending_q[0].id;
          burst_time_i <= pending_q[0].burst;
          priority_req_i <= pending_q[0].prio;
          last_i <= pending_q[0].last;
          valid_i <= 1'b1;
          void'(pending_q.pop_front());
        end else begin
          valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    int s;
    sched_res_t e;
    if (!rst_ni) begin
      ready_i <= 1'b0;
      stall_cnt <= 0;
    end else if (valid_o && ready_i) begin
      if (sched_q.size() == 0) begin
        $display("%0t: unexpected result id=%0h", $time, process_id_res_o);
        errors++;
      end else begin
        e = sched_q.pop_front();
        if (process_id_res_o !== e.id || burst_time_res_o !== e.burst ||
            wait_time_o !== e.wait_t || turnaround_time_o !== e.tat ||
            average_wait_o !== e.avg_wait || average_turnaround_o !== e.avg_tat ||
            overflowed_o !== e.ovf || final_res_o !== e.fin) begin
          $display("%0t: mismatch exp id=%0h bt=%0h w=%0h t=%0h aw=%0h at=%0h ov=%0b f=%0b",
                   $time, e.id, e.burst, e.wait_t, e.tat, e.avg_wait, e.avg_tat,
                   e.ovf, e.fin);
          $display("%0t:          act id=%0h bt=%0h w=%0h t=%0h aw=%0h at=%0h ov=%0b f=%0b",
                   $time, process_id_res_o, burst_time_res_o, wait_time_o,
                   turnaround_time_o, average_wait_o, average_turnaround_o,
                   overflowed_o, final_res_o);
          errors++;
        end
      end
      s = draw_pause();
      stall_cnt <= s;
      ready_i <= (s == 0);
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      ready_i <= (stall_cnt == 1);
    end else begin
      ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    int total;
    int n;
    int kind;
    bit narrow;
    logic [15:0] bt;
    errors = 0;
    rec_count = 0;
    rec_dropped = 1'b0;
    rst_ni = 1'b0;
    add_item(8'hff, 16'hffff, 8'hff, 1'b1, 1'b0);
    add_item(8'h00, 16'h0000, 8'h00, 1'b0, 1'b0);
    add_item(8'h01, 16'hffff, 8'hff, 1'b0, 1'b0);
    add_item(8'h02, 16'd100, 8'd7, 1'b0, 1'b0);
    add_item(8'h03, 16'd5, 8'd7, 1'b0, 1'b0);
    add_item(8'h04, 16'd9, 8'd0, 1'b1, 1'b0);
    add_item(8'h00, 16'h0000, 8'h00, 1'b1, 1'b1);
    total = 7;
    while (total < 180) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) n = $urandom_range(33, 36);
      else if (kind == 1) n = MaxProc;
      else n = $urandom_range(1, 8);
      narrow = $urandom_range(0, 1);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 5))
          0: bt = 16'h0000;
          1: bt = 16'hffff;
          default: bt = $urandom_range(0, 65535);
        endcase
        add_item($urandom_range(0, 255), bt,
                 narrow ? $urandom_range(0, 3) : $urandom_range(0, 255),
                 i == n - 1, (i == 0) && (kind == 2));
      end
      total += n;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_q.size() > 0 || valid_i) @(posedge clk_i);
    while (sched_q.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && sched_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/psw_pkg.sv
hw/rtl/psw_ram.sv
hw/rtl/psw_front.sv
hw/rtl/psw_back.sv
hw/rtl/priority_schedule_wait_times.sv
dv/tb_top.sv
